// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Needs clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define PPBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check
`define PPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ppbm_pkg.sv =====
// Package for the pulse period to BPM meter: widths, reset values, state types.
// No dependencies.
`default_nettype none

package ppbm_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int NUM_WIDTH      = 32;
  localparam int PERIOD_WIDTH   = 24;
  localparam int BPM_WIDTH      = 16;
  localparam int STEP_WIDTH     = $clog2(NUM_WIDTH);

  localparam logic [NUM_WIDTH-1:0] NUM_RESET = NUM_WIDTH'(240000000);
  localparam logic [BPM_WIDTH-1:0] BPM_MAX   = {BPM_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    PH_WAIT_LOW,
    PH_WAIT_HIGH,
    PH_HIGH,
    PH_LOW
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD
  } seq_state_t;

endpackage

`default_nettype wire

// ===== design/ppbm_in_if.sv =====
// Input channel: one timer tick carrying the sampled pulse level.
// Does not use ppbm_pkg; no dependencies.
`default_nettype none

interface ppbm_in_if;
  logic valid;
  logic ready;
  logic pulse_level;

  modport source (output valid, output pulse_level, input ready);
  modport sink   (input valid, input pulse_level, output ready);
endinterface

`default_nettype wire

// ===== design/ppbm_out_if.sv =====
// Result channel: period count and beat rate.
// Depends on ppbm_pkg for field widths.
`default_nettype none

interface ppbm_out_if;
  logic                              valid;
  logic                              ready;
  logic [ppbm_pkg::PERIOD_WIDTH-1:0] period_ticks;
  logic [ppbm_pkg::BPM_WIDTH-1:0]    beats_per_minute;

  modport source (output valid, output period_ticks, output beats_per_minute, input ready);
  modport sink   (input valid, input period_ticks, input beats_per_minute, output ready);
endinterface

`default_nettype wire

// ===== design/pulse_period_to_bpm_meter_unit.sv =====
// Pulse period to BPM meter, top level.
// Depends on ppbm_pkg, ppbm_in_if, ppbm_out_if and assert_macros.svh.
//
// Usage:
//   in_chan  : one transfer per timer tick, payload pulse_level.
//   out_chan : one transfer per measured period: period_ticks (count masked
//              to 24 bits) and beats_per_minute (numerator / count, saturated).
//   cfg_we / cfg_wdata : writes bpm_numerator; write only while idle.
// Timing:
//   A tick that does not close a period leaves the sequencer idle.
//   A tick that closes a period starts a restoring divider that retires one
//   quotient bit per cycle (ST_DIV) over every numerator bit, then loads the
//   output register (ST_LOAD); the result is valid as the unit returns to
//   idle, and the next tick is taken at the same time.
// Reset: numerator 240000000, phase waits for a low level, count cleared,
//   output register empty.
// Stall: a held result blocks every tick in the low phase, where a tick could
//   close the next period; other ticks are still taken.
`default_nettype none
`include "assert_macros.svh"

module pulse_period_to_bpm_meter_unit #(
  parameter int COUNT_BITS = ppbm_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ppbm_in_if.sink                             in_chan,
  ppbm_out_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [ppbm_pkg::NUM_WIDTH-1:0] cfg_wdata
);

  localparam int NW = ppbm_pkg::NUM_WIDTH;

  ppbm_pkg::phase_t                     phase_r, phase_nxt;
  ppbm_pkg::seq_state_t                 state_r, state_nxt;
  logic [COUNT_BITS-1:0]                tick_r, tick_nxt;
  logic [NW-1:0]                        num_cfg_r;
  logic [NW-1:0]                        num_r, num_nxt;
  logic [COUNT_BITS-1:0]                rem_r, rem_nxt;
  logic [COUNT_BITS-1:0]                div_r;
  logic [ppbm_pkg::STEP_WIDTH-1:0]      step_r, step_nxt;
  logic [COUNT_BITS:0]                  trial;
  logic                                 q_bit;
  logic                                 in_fire, out_fire, div_start;
  logic                                 out_valid_r;
  logic [ppbm_pkg::PERIOD_WIDTH-1:0]    out_period_r;
  logic [ppbm_pkg::BPM_WIDTH-1:0]       out_bpm_r;

  assign in_fire   = in_chan.valid & in_chan.ready;
  assign out_fire  = out_chan.valid & out_chan.ready;
  assign div_start = in_fire && (phase_r == ppbm_pkg::PH_LOW) && in_chan.pulse_level;

  // Tick phase machine
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    if (in_fire) begin
      unique case (phase_r)
        ppbm_pkg::PH_WAIT_LOW: begin
          tick_nxt = '0;
          if (!in_chan.pulse_level) phase_nxt = ppbm_pkg::PH_WAIT_HIGH;
        end
        ppbm_pkg::PH_WAIT_HIGH: begin
          if (in_chan.pulse_level) begin
            tick_nxt  = '0;
            phase_nxt = ppbm_pkg::PH_HIGH;
          end
        end
        ppbm_pkg::PH_HIGH: begin
          tick_nxt = tick_r + 1'b1;
          if (!in_chan.pulse_level) phase_nxt = ppbm_pkg::PH_LOW;
        end
        ppbm_pkg::PH_LOW: begin
          tick_nxt = tick_r + 1'b1;
          if (in_chan.pulse_level) phase_nxt = ppbm_pkg::PH_WAIT_LOW;
        end
        default: phase_nxt = ppbm_pkg::PH_WAIT_LOW;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppbm_pkg::ST_IDLE: if (div_start) state_nxt = ppbm_pkg::ST_DIV;
      ppbm_pkg::ST_DIV:  if (step_r == '0) state_nxt = ppbm_pkg::ST_LOAD;
      ppbm_pkg::ST_LOAD: state_nxt = ppbm_pkg::ST_IDLE;
      default:           state_nxt = ppbm_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    unique case (state_r) inside
      ppbm_pkg::ST_IDLE:
        in_chan.ready = !out_valid_r || (phase_r != ppbm_pkg::PH_LOW);
      ppbm_pkg::ST_DIV,
      ppbm_pkg::ST_LOAD:
        in_chan.ready = 1'b0;
      default:
        in_chan.ready = 1'b0;
    endcase
  end

  // Restoring divider step; a zero divisor yields all ones, which saturates
  assign trial = {rem_r, num_r[NW-1]};
  assign q_bit = (trial >= {1'b0, div_r});

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (div_start) begin
      num_nxt  = num_cfg_r;
      rem_nxt  = '0;
      step_nxt = ppbm_pkg::STEP_WIDTH'(NW - 1);
    end else if (state_r == ppbm_pkg::ST_DIV) begin
      num_nxt  = {num_r[NW-2:0], q_bit};
      rem_nxt  = q_bit ? COUNT_BITS'(trial - {1'b0, div_r}) : trial[COUNT_BITS-1:0];
      step_nxt = step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ppbm_pkg::PH_WAIT_LOW;
      state_r     <= ppbm_pkg::ST_IDLE;
      tick_r      <= '0;
      num_cfg_r   <= ppbm_pkg::NUM_RESET;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      step_r  <= step_nxt;
      if (cfg_we) num_cfg_r <= cfg_wdata;
      if (state_r == ppbm_pkg::ST_LOAD) out_valid_r <= 1'b1;
      else if (out_fire)                out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    if (div_start) begin
      div_r        <= tick_nxt;
      out_period_r <= ppbm_pkg::PERIOD_WIDTH'(tick_nxt);
    end
    if (state_r == ppbm_pkg::ST_LOAD) begin
      out_bpm_r <= (num_r[NW-1:ppbm_pkg::BPM_WIDTH] != '0) ? ppbm_pkg::BPM_MAX
                                                           : num_r[ppbm_pkg::BPM_WIDTH-1:0];
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.period_ticks     = out_period_r;
  assign out_chan.beats_per_minute = out_bpm_r;

  `PPBM_ASSERT_NOW(a_load_reg_free, state_r == ppbm_pkg::ST_LOAD, !out_valid_r, "output register busy at load")
  `PPBM_ASSERT_NEXT(a_div_ends, (state_r == ppbm_pkg::ST_DIV) && (step_r == '0), state_r == ppbm_pkg::ST_LOAD, "divider overran")
  `PPBM_ASSERT_NOW(a_div_phase, state_r == ppbm_pkg::ST_DIV, phase_r == ppbm_pkg::PH_WAIT_LOW, "phase not reset after period")
  `PPBM_ASSERT_NEXT(a_start_div, div_start, state_r == ppbm_pkg::ST_DIV, "divider not started")

endmodule

`default_nettype wire
